FILE: design/student_t_log_likelihood_unit_macros.svh
// Assertion macros shared by the log-likelihood unit.
`ifndef STUDENT_T_LOG_LIKELIHOOD_UNIT_MACROS_SVH
`define STUDENT_T_LOG_LIKELIHOOD_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define STLL_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define STLL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define STLL_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define STLL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: design/stll_pkg.sv
package stll_pkg;

    localparam int DATA_W = 32;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [1:0] CMD_MEAN   = 2'd0;
    localparam logic [1:0] CMD_FACTOR = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [1:0] REG_DIMENSION = 2'd0;
    localparam logic [1:0] REG_DOF       = 2'd1;
    localparam logic [1:0] REG_NORM      = 2'd2;
    localparam logic [1:0] REG_COEF      = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MEAN,
        ST_MAC,
        ST_DIV,
        ST_DIVWAIT,
        ST_SQUARE,
        ST_ACCUM,
        ST_QUOT,
        ST_QWAIT,
        ST_LOGWAIT,
        ST_SCALE
    } state_t;

    typedef enum logic [2:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQUARE,
        LG_SCALE,
        LG_DONE
    } log_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

FILE: design/student_t_log_likelihood_unit.sv
// Student-t log-likelihood unit. Load items (cmd 0 for a mean element, cmd 1
// for a Cholesky factor entry) are written into on-chip memories as they are
// accepted. Sample items (cmd 2) carry the elements of one vector in index
// order. Element k takes k multiply-accumulates streamed from the factor and
// vector memories at one per cycle, a restoring division by the diagonal,
// then squaring and accumulation. The element that completes the vector adds
// a division by the degrees of freedom and a log unit of normalize steps plus
// one squaring per fraction bit. The divider produces one bit per cycle. One
// item is processed at a time; in_stall stays high until it is done. A
// finished result waits in the output register, and only the item that
// completes the next vector is held until that register has room.
// Configuration must be written through the APB-style port only while no
// item is in progress; the block itself does not enforce it. A zero
// diagonal or any saturation sets status to one on the result.

`include "student_t_log_likelihood_unit_macros.svh"

module student_t_log_likelihood_unit
    import stll_pkg::*;
#(
    parameter int MAX_DIM   = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [3:0]  row_index,
    input  logic [3:0]  col_index,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] log_likelihood,
    output logic        status
);

    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW  = $clog2(MAX_DIM + 1);
    localparam int FD  = MAX_DIM * MAX_DIM;
    localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
    localparam int VD  = 2 * MAX_DIM;
    localparam int VAW = $clog2(VD);
    localparam int LW  = FRAC_BITS + 7;
    localparam int PW  = LW + 31;

    // Configuration registers.
    logic [4:0]  dim_cfg_reg;
    logic [9:0]  dof_cfg_reg;
    logic [31:0] norm_cfg_reg;
    logic [30:0] coef_cfg_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_cfg_reg  <= 5'd1;
            dof_cfg_reg  <= 10'd1;
            norm_cfg_reg <= '0;
            coef_cfg_reg <= 31'd65536;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_DIMENSION: dim_cfg_reg  <= pwdata[4:0];
                REG_DOF:       dof_cfg_reg  <= pwdata[9:0];
                REG_NORM:      norm_cfg_reg <= pwdata;
                REG_COEF:      coef_cfg_reg <= pwdata[30:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DIMENSION: prdata = {27'd0, dim_cfg_reg};
            REG_DOF:       prdata = {22'd0, dof_cfg_reg};
            REG_NORM:      prdata = norm_cfg_reg;
            REG_COEF:      prdata = {1'b0, coef_cfg_reg};
            default:       prdata = '0;
        endcase
    end

    // Effective dimension: zero acts as one, anything above MAX_DIM as MAX_DIM.
    logic [CW-1:0] dim_eff;
    always_comb
    begin
        if (dim_cfg_reg == 5'd0)
        begin
            dim_eff = CW'(1);
        end
        else if (32'(dim_cfg_reg) > MAX_DIM)
        begin
            dim_eff = CW'(MAX_DIM);
        end
        else
        begin
            dim_eff = CW'(dim_cfg_reg);
        end
    end

    // Memories: factor store, and a vector store holding the mean in the
    // lower half and the solved values in the upper half.
    logic             f_we, v_we;
    logic [FAW-1:0]   f_waddr, f_raddr;
    logic [VAW-1:0]   v_waddr, v_raddr;
    logic [31:0]      f_wdata, v_wdata, f_rdata, v_rdata;

    stll_store #(.DEPTH(FD), .AW(FAW), .WIDTH(DATA_W)) u_factor (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    stll_store #(.DEPTH(VD), .AW(VAW), .WIDTH(DATA_W)) u_vector (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    // Divider, shared by both divisions, and log unit.
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic             log_start;
    logic [63:0]      log_t;
    logic             log_done;
    logic [LW-1:0]    lnv;

    stll_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    stll_log #(.FRAC_BITS(FRAC_BITS)) u_log (
        .clk(clk), .rst_n(rst_n), .start(log_start), .t(log_t),
        .done(log_done), .lnv(lnv)
    );

    // Sequencer state.
    state_t              state_reg, state_next;
    logic [CW-1:0]       ctr_reg, ctr_next;
    logic [63:0]         dist_reg, dist_next;
    logic                err_reg, err_next;
    logic                out_valid_reg, out_valid_next;
    logic                rd_v_reg, rd_v_next;
    logic                mul_v_reg, mul_v_next;
    logic signed [31:0]  val_reg, val_next;
    logic [IW-1:0]       k_reg, k_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic signed [63:0]  acc_reg, acc_next;
    logic signed [31:0]  diag_reg, diag_next;
    logic signed [31:0]  z_reg, z_next;
    logic                neg_reg, neg_next;
    logic [63:0]         sq_reg, sq_next;
    logic [PW-1:0]       lnprod_reg, lnprod_next;
    logic signed [31:0]  ll_reg, ll_next;
    logic                st_reg, st_next;
    logic                out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ctr_reg       <= '0;
            dist_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            dist_reg      <= dist_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            rd_v_reg      <= rd_v_next;
            mul_v_reg     <= mul_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        diag_reg   <= diag_next;
        z_reg      <= z_next;
        neg_reg    <= neg_next;
        sq_reg     <= sq_next;
        lnprod_reg <= lnprod_next;
        ll_reg     <= ll_next;
        st_reg     <= st_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        logic [CW-1:0]      k_sel;
        logic [CW-1:0]      k_inc;
        logic signed [31:0] resid;
        logic               resid_sat;
        logic [32:0]        resid_mag;
        logic [63:0]        qmag;
        logic signed [63:0] res_wide;
        logic [9:0]         eta;

        state_next     = state_reg;
        ctr_next       = ctr_reg;
        dist_next      = dist_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        rd_v_next      = 1'b0;
        mul_v_next     = 1'b0;
        val_next       = val_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        diag_next      = diag_reg;
        z_next         = z_reg;
        neg_next       = neg_reg;
        sq_next        = sq_reg;
        lnprod_next    = lnprod_reg;
        ll_next        = ll_reg;
        st_next        = st_reg;
        out_load       = 1'b0;

        f_we    = 1'b0;
        v_we    = 1'b0;
        f_waddr = FAW'(32'(row_index) * MAX_DIM + 32'(col_index));
        f_wdata = value;
        v_waddr = VAW'(row_index);
        v_wdata = value;
        f_raddr = FAW'(32'(k_reg) * MAX_DIM + 32'(k_reg));
        v_raddr = VAW'(k_reg);

        div_req.start    = 1'b0;
        div_req.dividend = dist_reg;
        div_req.divisor  = '0;
        log_start        = 1'b0;
        log_t            = div_rsp.quotient + (64'd1 << FRAC_BITS);

        k_sel = (ctr_reg >= dim_eff) ? CW'(dim_eff - CW'(1)) : ctr_reg;
        k_inc = CW'(k_reg) + CW'(1);
        eta   = (dof_cfg_reg == 10'd0) ? 10'd1 : dof_cfg_reg;

        // Residual saturated to 32 bits.
        resid_sat = 1'b0;
        if (acc_reg > 64'sd2147483647)
        begin
            resid     = 32'sh7FFFFFFF;
            resid_sat = 1'b1;
        end
        else if (acc_reg < -64'sd2147483648)
        begin
            resid     = 32'sh80000000;
            resid_sat = 1'b1;
        end
        else
        begin
            resid = acc_reg[31:0];
        end
        resid_mag = resid[31] ? 33'(-{resid[31], resid}) : {1'b0, resid};
        qmag      = div_rsp.quotient;

        res_wide = $signed({{32{norm_cfg_reg[31]}}, norm_cfg_reg})
                 - $signed(64'(lnprod_reg >> FRAC_BITS));

        // The output register empties whenever its item is taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        CMD_MEAN:
                        begin
                            v_we = (32'(row_index) < MAX_DIM);
                        end
                        CMD_FACTOR:
                        begin
                            f_we = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
                        end
                        CMD_SAMPLE:
                        begin
                            val_next   = value;
                            k_next     = IW'(k_sel);
                            state_next = ST_FETCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                // Read the mean and the diagonal of row k.
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                diag_next  = f_rdata;
                acc_next   = 64'(val_reg) - 64'($signed(v_rdata));
                idx_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                // Streamed read, multiply and accumulate over the row.
                f_raddr = FAW'(32'(k_reg) * MAX_DIM + 32'(idx_reg));
                v_raddr = VAW'(32'(idx_reg) + MAX_DIM);
                if (idx_reg < k_reg)
                begin
                    rd_v_next = 1'b1;
                    idx_next  = idx_reg + IW'(1);
                end
                if (rd_v_reg)
                begin
                    prod_next = $signed(f_rdata) * $signed(v_rdata);
                end
                if (mul_v_reg)
                begin
                    acc_next = acc_reg - (prod_reg >>> FRAC_BITS);
                end
                mul_v_next = rd_v_reg;
                if (idx_reg == k_reg && !rd_v_reg && !mul_v_reg)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (resid_sat)
                begin
                    err_next = 1'b1;
                end
                if (diag_reg == 32'sd0)
                begin
                    err_next   = 1'b1;
                    z_next     = '0;
                    state_next = ST_SQUARE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'(resid_mag) << FRAC_BITS;
                    div_req.divisor  = diag_reg[31] ? 32'(-diag_reg) : diag_reg;
                    neg_next         = resid[31] ^ diag_reg[31];
                    state_next       = ST_DIVWAIT;
                end
            end
            ST_DIVWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (neg_reg)
                    begin
                        if (qmag > 64'h0000_0000_8000_0000)
                        begin
                            z_next   = 32'sh80000000;
                            err_next = 1'b1;
                        end
                        else
                        begin
                            z_next = -qmag[31:0];
                        end
                    end
                    else
                    begin
                        if (qmag > 64'h0000_0000_7FFF_FFFF)
                        begin
                            z_next   = 32'sh7FFFFFFF;
                            err_next = 1'b1;
                        end
                        else
                        begin
                            z_next = qmag[31:0];
                        end
                    end
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                sq_next    = 64'(z_reg) * 64'(z_reg);
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                dist_next = dist_reg + (sq_reg >> FRAC_BITS);
                v_we      = 1'b1;
                v_waddr   = VAW'(32'(k_reg) + MAX_DIM);
                v_wdata   = z_reg;
                ctr_next  = k_inc;
                if (k_inc < dim_eff)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = dist_reg;
                div_req.divisor  = {22'd0, eta};
                state_next       = ST_QWAIT;
            end
            ST_QWAIT:
            begin
                if (div_rsp.done)
                begin
                    log_start  = 1'b1;
                    state_next = ST_LOGWAIT;
                end
            end
            ST_LOGWAIT:
            begin
                if (log_done)
                begin
                    lnprod_next = PW'(coef_cfg_reg) * PW'(lnv);
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                // Wait for room in the output register, then finish the vector.
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    if (res_wide > 64'sd2147483647)
                    begin
                        ll_next = 32'sh7FFFFFFF;
                        st_next = 1'b1;
                    end
                    else if (res_wide < -64'sd2147483648)
                    begin
                        ll_next = 32'sh80000000;
                        st_next = 1'b1;
                    end
                    else
                    begin
                        ll_next = res_wide[31:0];
                        st_next = err_reg;
                    end
                    out_valid_next = 1'b1;
                    ctr_next       = '0;
                    dist_next      = '0;
                    err_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign log_likelihood = ll_reg;
    assign status         = st_reg;

    `STLL_ASSERT_IMPLY(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)
    `STLL_ASSERT_NEXT(a_zero_diag_flags, clk, rst_n, state_reg == ST_DIV && diag_reg == 32'sd0, err_reg)
    `STLL_ASSERT_NEXT(a_result_clears, clk, rst_n, out_load, ctr_reg == '0 && dist_reg == '0 && !err_reg)
    `STLL_ASSERT_IMPLY(a_ctr_range, clk, rst_n, 1'b1, 32'(ctr_reg) <= MAX_DIM)

endmodule

FILE: design/stll_store.sv
module stll_store
    import stll_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/stll_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module stll_div
    import stll_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [32:0] rem_sh;
    logic        take;

    assign rem_sh = {rem_reg, dvd_reg[63]};
    assign take   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= 32'(rem_sh - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
            end
            dvd_reg <= {dvd_reg[62:0], take};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

FILE: design/stll_log.sv
// Natural log of a fixed-point value of at least one: normalize by single-bit
// shifts, then one squaring round per fraction bit of log2, then scale by ln 2.
module stll_log
    import stll_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           t,
    output logic                  done,
    output logic [FRAC_BITS+6:0]  lnv
);

    localparam int MW = FRAC_BITS + 1;
    localparam int LW = FRAC_BITS + 7;
    localparam int RW = $clog2(FRAC_BITS + 1);

    log_state_t          state_reg, state_next;
    logic [63:0]         t_reg, t_next;
    logic [6:0]          n_reg, n_next;
    logic [MW-1:0]       m_reg, m_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [RW-1:0]       rnd_reg, rnd_next;
    logic [LW-1:0]       lnv_reg, lnv_next;

    logic [2*MW-1:0]     sq;
    logic [MW:0]         sq_sh;
    logic [LW-1:0]       lg;
    logic [LW+31:0]      lg_prod;

    assign sq      = m_reg * m_reg;
    assign sq_sh   = sq[FRAC_BITS +: MW+1];
    assign lg      = {n_reg, frac_reg};
    assign lg_prod = lg * LN2_Q32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        n_reg    <= n_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        rnd_reg  <= rnd_next;
        lnv_reg  <= lnv_next;
    end

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        rnd_next   = rnd_reg;
        lnv_next   = lnv_reg;
        done       = 1'b0;
        case (state_reg)
            LG_IDLE:
            begin
                if (start)
                begin
                    t_next     = t;
                    n_next     = '0;
                    state_next = LG_NORM;
                end
            end
            LG_NORM:
            begin
                // Shift until the value lies in [1, 2).
                if (t_reg >= (64'd2 << FRAC_BITS))
                begin
                    t_next = t_reg >> 1;
                    n_next = n_reg + 7'd1;
                end
                else
                begin
                    m_next     = t_reg[MW-1:0];
                    frac_next  = '0;
                    rnd_next   = '0;
                    state_next = LG_SQUARE;
                end
            end
            LG_SQUARE:
            begin
                if (sq_sh >= ((MW+1)'(2) << FRAC_BITS))
                begin
                    m_next    = sq_sh[MW:1];
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    m_next    = sq_sh[MW-1:0];
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b0};
                end
                rnd_next = rnd_reg + RW'(1);
                if (rnd_reg == RW'(FRAC_BITS - 1))
                begin
                    state_next = LG_SCALE;
                end
            end
            LG_SCALE:
            begin
                lnv_next   = lg_prod[LW+31:32];
                state_next = LG_DONE;
            end
            LG_DONE:
            begin
                done       = 1'b1;
                state_next = LG_IDLE;
            end
            default:
            begin
                state_next = LG_IDLE;
            end
        endcase
    end

    assign lnv = lnv_reg;

endmodule
